// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker of the log string escaper.
// Every macro samples on the rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication that is evaluated at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks that a signal never goes unknown outside reset.
`define ASSERT_KNOWN(label, clk, rst_n, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
        else $error("signal unknown");

`endif

// ===== rtl/lse_pkg.sv =====
// Package of the log string escaper: payload types, command codes and helpers.
// It depends on nothing; every other file of the block but assert_macros.svh uses it.
package lse_pkg;

    localparam int LIMIT_W     = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [1:0] CFG_CLASS_MODE   = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_LIMIT = 2'd1;

    localparam logic [1:0] MODE_HEX_ONLY = 2'd0;
    localparam logic [1:0] MODE_PUNCT    = 2'd1;
    localparam logic [1:0] MODE_FILTER   = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_STAR      = 8'h2a;
    localparam logic [7:0] CHAR_LPAREN    = 8'h28;
    localparam logic [7:0] CHAR_RPAREN    = 8'h29;
    localparam logic [7:0] CHAR_DOT       = 8'h2e;
    localparam logic [7:0] CHAR_LOW       = 8'd32;
    localparam logic [7:0] CHAR_HIGH      = 8'd126;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_BSL,
        KIND_HEX,
        KIND_TRUNC
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       truncated;
    } out_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    function automatic kind_t classify(input logic [7:0] c, input logic [1:0] mode);
        logic np;
        np = (c < CHAR_LOW) || (c > CHAR_HIGH);
        case (mode)
            MODE_HEX_ONLY:
                classify = (np || c == CHAR_QUOTE || c == CHAR_BACKSLASH) ? KIND_HEX
                                                                          : KIND_PLAIN;
            MODE_PUNCT:
                if (np || c == CHAR_STAR)
                    classify = KIND_HEX;
                else if (c == CHAR_BACKSLASH || c == CHAR_QUOTE)
                    classify = KIND_BSL;
                else
                    classify = KIND_PLAIN;
            default:
                classify = (np || c == CHAR_STAR || c == CHAR_LPAREN || c == CHAR_RPAREN
                            || c == CHAR_BACKSLASH || c == CHAR_QUOTE) ? KIND_HEX
                                                                       : KIND_PLAIN;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    function automatic logic [1:0] kind_need(input kind_t kind);
        case (kind)
            KIND_HEX: kind_need = 2'd3;
            KIND_BSL: kind_need = 2'd2;
            default:  kind_need = 2'd1;
        endcase
    endfunction

endpackage

// ===== rtl/lse_queue.sv =====
// Short command queue between the front and back parts of the escaper.
// Depends on lse_pkg for the command type and the queue depth.
module lse_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lse_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output lse_pkg::cmd_t head_cmd
);

    lse_pkg::cmd_t mem [lse_pkg::QUEUE_DEPTH];

    logic [lse_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lse_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lse_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full       = (count_reg == lse_pkg::QUEUE_CNT_W'(lse_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/lse_front.sv =====
// Front part of the escaper: configuration registers, byte classification and budget.
// Depends on lse_pkg; pushes one command per emitting input byte into lse_queue.
module lse_front #(
    parameter logic [12:0] BUDGET_CAP = 13'd8188
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lse_pkg::in_item_t in_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [12:0]       cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output lse_pkg::cmd_t     q_cmd
);

    logic [1:0]                  class_mode_reg, class_mode_next;
    logic [lse_pkg::LIMIT_W-1:0] output_limit_reg, output_limit_next;
    logic [lse_pkg::LIMIT_W-1:0] budget_reg, budget_next;
    logic                        cut_off_reg, cut_off_next;
    logic                        active_reg, active_next;
    logic [lse_pkg::LIMIT_W-1:0] budget_eff;
    logic                        cut_eff;
    logic                        accept;
    lse_pkg::kind_t              kind;
    logic [lse_pkg::LIMIT_W-1:0] need;

    assign in_stall  = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        class_mode_next   = class_mode_reg;
        output_limit_next = output_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lse_pkg::CFG_CLASS_MODE:   class_mode_next = cfg_data[1:0];
                lse_pkg::CFG_OUTPUT_LIMIT: output_limit_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (active_reg)
            budget_eff = budget_reg;
        else
            budget_eff = (output_limit_reg < BUDGET_CAP) ? output_limit_reg : BUDGET_CAP;
        cut_eff = active_reg && cut_off_reg;
        kind    = lse_pkg::classify(in_data.in_byte, class_mode_reg);
        need    = {{(lse_pkg::LIMIT_W-2){1'b0}}, lse_pkg::kind_need(kind)};

        budget_next  = budget_reg;
        cut_off_next = cut_off_reg;
        active_next  = active_reg;
        q_push       = 1'b0;
        q_cmd.kind   = kind;
        q_cmd.data   = in_data.in_byte;
        q_cmd.last   = in_data.in_last;

        if (accept)
        begin
            budget_next  = budget_eff;
            cut_off_next = cut_eff;
            if (!cut_eff)
            begin
                q_push = 1'b1;
                if (need <= budget_eff)
                    budget_next = budget_eff - need;
                else
                begin
                    // The second dot of the marker always closes the output string.
                    q_cmd.kind   = lse_pkg::KIND_TRUNC;
                    q_cmd.last   = 1'b1;
                    cut_off_next = 1'b1;
                end
            end
            if (in_data.in_last)
            begin
                active_next  = 1'b0;
                cut_off_next = 1'b0;
            end
            else
                active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_mode_reg   <= lse_pkg::MODE_HEX_ONLY;
            output_limit_reg <= BUDGET_CAP;
            budget_reg       <= '0;
            cut_off_reg      <= 1'b0;
            active_reg       <= 1'b0;
        end
        else
        begin
            class_mode_reg   <= class_mode_next;
            output_limit_reg <= output_limit_next;
            budget_reg       <= budget_next;
            cut_off_reg      <= cut_off_next;
            active_reg       <= active_next;
        end
    end

endmodule

// ===== rtl/lse_back.sv =====
// Back part of the escaper: expands each queued command into one to three output bytes.
// Depends on lse_pkg; reads the head of lse_queue and drives the output register.
module lse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  lse_pkg::cmd_t      head_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output lse_pkg::out_item_t out_data
);

    logic [1:0]         phase_reg, phase_next;
    logic               out_valid_reg, out_valid_next;
    lse_pkg::out_item_t out_data_reg, out_data_next;
    logic [7:0]         gen_byte;
    logic               gen_final;
    logic               gen_trunc;
    logic               advance;

    assign advance   = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        gen_byte  = head_cmd.data;
        gen_final = 1'b1;
        gen_trunc = 1'b0;
        unique case (head_cmd.kind)
            lse_pkg::KIND_PLAIN:
            begin
                gen_byte  = head_cmd.data;
                gen_final = 1'b1;
            end
            lse_pkg::KIND_BSL:
            begin
                gen_byte  = (phase_reg == 2'd0) ? lse_pkg::CHAR_BACKSLASH : head_cmd.data;
                gen_final = (phase_reg == 2'd1);
            end
            lse_pkg::KIND_HEX:
            begin
                case (phase_reg)
                    2'd0:    gen_byte = lse_pkg::CHAR_BACKSLASH;
                    2'd1:    gen_byte = lse_pkg::hex_char(head_cmd.data[7:4]);
                    default: gen_byte = lse_pkg::hex_char(head_cmd.data[3:0]);
                endcase
                gen_final = (phase_reg == 2'd2);
            end
            lse_pkg::KIND_TRUNC:
            begin
                gen_byte  = lse_pkg::CHAR_DOT;
                gen_final = (phase_reg == 2'd1);
                gen_trunc = 1'b1;
            end
            default:
            begin
                gen_byte  = head_cmd.data;
                gen_final = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        if (advance)
        begin
            out_valid_next         = 1'b1;
            out_data_next.out_byte = gen_byte;
            out_data_next.out_last = head_cmd.last && gen_final;
            out_data_next.truncated = gen_trunc;
            q_pop                  = gen_final;
            phase_next             = gen_final ? 2'd0 : phase_reg + 2'd1;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/log_string_escaper.sv =====
// Top level of the log string escaper; joins lse_front, lse_queue and lse_back from lse_pkg.
// An accepted byte goes into lse_queue, and lse_back expands it into the output register.
// Throughput: one output byte per cycle while a command is queued and out_stall is low;
// a byte gives one, two or three (hex escape) bytes; bytes dropped after a cut give none.
// Reset is asynchronous and active low; it empties the queue and the output register and
// loads class_mode 0 and output_limit min(OUT_BUFFER_BYTES-4, 8191).
module log_string_escaper #(
    parameter int OUT_BUFFER_BYTES = 8192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lse_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lse_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data
);

    localparam int CAP_RAW = OUT_BUFFER_BYTES - 4;
    localparam int CAP_MAX = (1 << lse_pkg::LIMIT_W) - 1;
    localparam logic [lse_pkg::LIMIT_W-1:0] BUDGET_CAP =
        lse_pkg::LIMIT_W'((CAP_RAW > CAP_MAX) ? CAP_MAX : CAP_RAW);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          head_valid;
    lse_pkg::cmd_t q_cmd;
    lse_pkg::cmd_t head_cmd;

    lse_front #(
        .BUDGET_CAP(BUDGET_CAP)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    lse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .head_valid(head_valid),
        .head_cmd  (head_cmd)
    );

    lse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_cmd  (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/lse_checker.sv =====
// Port checker of the log string escaper and the bind that attaches it to the top level.
// Depends on lse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lse_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input lse_pkg::out_item_t out_data
);

    `ASSERT_CLK(a_out_hold, clk, rst_n,
        out_valid && out_stall |=> out_valid && $stable(out_data))
    `ASSERT_CLK(a_trunc_dot, clk, rst_n,
        out_valid && out_data.truncated |-> out_data.out_byte == lse_pkg::CHAR_DOT)
    `ASSERT_CLK(a_trunc_pair, clk, rst_n,
        out_valid && !out_stall && out_data.truncated && !out_data.out_last
        |=> out_valid && out_data.truncated && out_data.out_last)

endmodule

bind log_string_escaper lse_port_checker u_lse_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

// ===== tb/lse_checker.sv =====
// Checker for the log string escaper: watches the request, result and register channels,
// predicts the escaped byte stream and compares every accepted result with it.
// Depends on lse_pkg for the payload types, register indexes and character codes.
module lse_checker #(
    parameter int OUT_BUFFER_BYTES = 8192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  lse_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  lse_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    output int                 pending,
    output int                 errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RAW_CAP  = OUT_BUFFER_BYTES - 4;
    localparam logic [12:0] ROOM_CAP = (RAW_CAP > 8191) ? 13'd8191 : 13'(RAW_CAP);

    lse_pkg::out_item_t escaped_q[$];
    logic [1:0]         cur_mode;
    logic [12:0]        cur_limit;
    logic [12:0]        room;
    logic               clipped;
    logic               mid_string;

    function automatic lse_pkg::kind_t byte_kind(input logic [7:0] c, input logic [1:0] m);
        if (c < lse_pkg::CHAR_LOW || c > lse_pkg::CHAR_HIGH)
            return lse_pkg::KIND_HEX;
        case (c) inside
            lse_pkg::CHAR_QUOTE, lse_pkg::CHAR_BACKSLASH:
                return (m == lse_pkg::MODE_PUNCT) ? lse_pkg::KIND_BSL : lse_pkg::KIND_HEX;
            lse_pkg::CHAR_STAR:
                return (m == lse_pkg::MODE_HEX_ONLY) ? lse_pkg::KIND_PLAIN : lse_pkg::KIND_HEX;
            lse_pkg::CHAR_LPAREN, lse_pkg::CHAR_RPAREN:
                return (m == lse_pkg::MODE_HEX_ONLY || m == lse_pkg::MODE_PUNCT)
                       ? lse_pkg::KIND_PLAIN : lse_pkg::KIND_HEX;
            default:
                return lse_pkg::KIND_PLAIN;
        endcase
    endfunction

    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return 8'h61 + 8'(nib) - 8'd10;
    endfunction

    task automatic push_escaped(input logic [7:0] b, input logic last, input logic cut);
        lse_pkg::out_item_t item;
        item.out_byte  = b;
        item.out_last  = last;
        item.truncated = cut;
        escaped_q.push_back(item);
    endtask

    task automatic escape_byte(input lse_pkg::in_item_t req);
        lse_pkg::kind_t k;
        logic [12:0]    need;
        if (!mid_string)
        begin
            room    = (cur_limit < ROOM_CAP) ? cur_limit : ROOM_CAP;
            clipped = 1'b0;
        end
        if (!clipped)
        begin
            k    = byte_kind(req.in_byte, cur_mode);
            need = (k == lse_pkg::KIND_HEX) ? 13'd3 : (k == lse_pkg::KIND_BSL) ? 13'd2 : 13'd1;
            if (need <= room)
            begin
                room = room - need;
                case (k)
                    lse_pkg::KIND_PLAIN:
                        push_escaped(req.in_byte, req.in_last, 1'b0);
                    lse_pkg::KIND_BSL:
                    begin
                        push_escaped(lse_pkg::CHAR_BACKSLASH, 1'b0, 1'b0);
                        push_escaped(req.in_byte, req.in_last, 1'b0);
                    end
                    default:
                    begin
                        push_escaped(lse_pkg::CHAR_BACKSLASH, 1'b0, 1'b0);
                        push_escaped(nibble_ascii(req.in_byte[7:4]), 1'b0, 1'b0);
                        push_escaped(nibble_ascii(req.in_byte[3:0]), req.in_last, 1'b0);
                    end
                endcase
            end
            else
            begin
                push_escaped(lse_pkg::CHAR_DOT, 1'b0, 1'b1);
                push_escaped(lse_pkg::CHAR_DOT, 1'b1, 1'b1);
                clipped = 1'b1;
            end
        end
        mid_string = !req.in_last;
        if (req.in_last)
            clipped = 1'b0;
    endtask

    task automatic check_result(input lse_pkg::out_item_t got);
        lse_pkg::out_item_t want;
        if (escaped_q.size() == 0)
        begin
            $error("unexpected result: out_byte %02h out_last %0b truncated %0b",
                   got.out_byte, got.out_last, got.truncated);
            errors++;
            return;
        end
        want = escaped_q.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            errors++;
        end
        if (got.out_last !== want.out_last)
        begin
            $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
            errors++;
        end
        if (got.truncated !== want.truncated)
        begin
            $error("truncated: expected %0b, got %0b", want.truncated, got.truncated);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escaped_q.delete();
            cur_mode   = lse_pkg::MODE_HEX_ONLY;
            cur_limit  = ROOM_CAP;
            room       = '0;
            clipped    = 1'b0;
            mid_string = 1'b0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lse_pkg::CFG_CLASS_MODE)
                    cur_mode = cfg_data[1:0];
                else if (cfg_index == lse_pkg::CFG_OUTPUT_LIMIT)
                    cur_limit = cfg_data;
            end
            if (in_valid && !in_stall)
                escape_byte(in_data);
            if (out_valid && !out_stall)
                check_result(out_data);
            pending <= escaped_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the log string escaper testbench: clock, reset, request and register stimulus,
// random stalls on both channels and the final verdict.
// Depends on lse_pkg, the log_string_escaper block and the lse_checker module.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STRING = 12;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    lse_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    lse_pkg::out_item_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = lse_pkg::CFG_CLASS_MODE;
    logic [12:0]        cfg_data = '0;

    int          pending;
    int          errors;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          requests_sent = 0;
    int          strings_sent = 0;
    int          settings_used = 1;
    int unsigned cycle_count = 0;
    logic [7:0]  str_q[$];

    log_string_escaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lse_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, in_last: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_str();
        foreach (str_q[i])
            send_byte(str_q[i], i == str_q.size() - 1);
        requests_sent += str_q.size();
        strings_sent++;
    endtask

    // Waits until every predicted byte has come out, then lets the pipeline empty
    // of requests that were dropped without a result.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [1:0] mode, input logic [12:0] limit);
        cfg_valid <= 1'b1;
        cfg_index <= lse_pkg::CFG_CLASS_MODE;
        cfg_data  <= {11'd0, mode};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= lse_pkg::CFG_OUTPUT_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] marks[6];
        int         r;
        marks = '{lse_pkg::CHAR_BACKSLASH, lse_pkg::CHAR_QUOTE, lse_pkg::CHAR_STAR,
                  lse_pkg::CHAR_LPAREN, lse_pkg::CHAR_RPAREN, lse_pkg::CHAR_DOT};
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'($urandom_range(32, 126));
        if (r < 75)
            return marks[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_phase(input logic [1:0] mode, input logic [12:0] limit,
                             input int n_items);
        int sent;
        int len;
        settle();
        write_config(mode, limit);
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            str_q.delete();
            repeat (len)
                str_q.push_back(pick_byte());
            send_str();
            sent += len;
        end
    endtask

    initial
    begin
        send_idle = 23;
        recv_idle = 77;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        str_q = '{8'h00, lse_pkg::CHAR_HIGH, 8'h7f, lse_pkg::CHAR_QUOTE,
                  lse_pkg::CHAR_BACKSLASH, lse_pkg::CHAR_STAR};
        send_str();

        settle();
        write_config(lse_pkg::MODE_PUNCT, 13'd8188);
        str_q = '{lse_pkg::CHAR_LOW, lse_pkg::CHAR_QUOTE, lse_pkg::CHAR_BACKSLASH,
                  lse_pkg::CHAR_STAR, lse_pkg::CHAR_LPAREN};
        send_str();

        settle();
        write_config(lse_pkg::MODE_SPARE, 13'd0);
        str_q = '{8'h41};
        send_str();
        str_q = '{8'h42, lse_pkg::CHAR_RPAREN};
        send_str();

        settle();
        write_config(lse_pkg::MODE_FILTER, 13'd4);
        str_q = '{lse_pkg::CHAR_LPAREN, 8'h41, lse_pkg::CHAR_RPAREN, 8'h1f};
        send_str();

        run_phase(lse_pkg::MODE_PUNCT, 13'd4, 28);
        run_phase(lse_pkg::MODE_FILTER, 13'd8191, 28);

        send_idle = 77;
        recv_idle = 23;
        run_phase(lse_pkg::MODE_SPARE, 13'($urandom_range(0, 3)), 28);
        run_phase(lse_pkg::MODE_HEX_ONLY, 13'($urandom_range(5, 40)), 28);

        send_idle = 0;
        recv_idle = 0;
        run_phase(lse_pkg::MODE_PUNCT, 13'($urandom_range(4, 24)), 28);
        run_phase(lse_pkg::MODE_FILTER, 13'd8188, 28);

        // A string made only of non-printing bytes under the widest limit.
        settle();
        write_config(lse_pkg::MODE_HEX_ONLY, 13'd8191);
        str_q.delete();
        repeat (LONG_STRING)
            str_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                        : 8'($urandom_range(127, 255)));
        send_str();

        settle();
        repeat (8)
            @(posedge clk);
        if (pending != 0)
            $error("%0d expected result bytes never arrived", pending);
        $display("Sent %0d requests in %0d strings under %0d register settings.",
                 requests_sent, strings_sent, settings_used);
        $display("Modes 0 to 3 and limits 0 to 8191 ran with and without stalls on both sides.");
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lse_pkg.sv
rtl/lse_queue.sv
rtl/lse_front.sv
rtl/lse_back.sv
rtl/log_string_escaper.sv
rtl/lse_checker.sv
tb/lse_checker.sv
tb/tb_top.sv
